FILE: src/tfwa_pkg.sv
`timescale 1ns / 1ps

package tfwa_pkg;

  // Fixed field widths of the ports.
  localparam int AVG_W      = 24;
  localparam int WLEN_W     = 6;
  localparam int THR_W      = 15;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 15;
  localparam int FRAC_BITS  = 8;

  // Register reset values.
  localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(8);
  localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(3);

  // Saturation limits of the average.
  localparam logic [AVG_W-1:0] AVG_MAX = {1'b0, {(AVG_W-1){1'b1}}};
  localparam logic [AVG_W-1:0] AVG_MIN = {1'b1, {(AVG_W-1){1'b0}}};

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_WINDOW_LEN = 2'd0,
    REG_THRESHOLD  = 2'd1,
    REG_USE_ABS    = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_CHECK = 2'd1,
    ST_DIV   = 2'd2
  } ctl_state_t;

  // Per-cell control: load the new contribution, or take the neighbor's entry.
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

endpackage

FILE: src/tfwa_ifs.sv
`timescale 1ns / 1ps

interface tfwa_in_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          row_end;

  modport source (output valid, output sample, output row_end, input ready);
  modport sink (input valid, input sample, input row_end, output ready);
endinterface

interface tfwa_out_if import tfwa_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [AVG_W-1:0] average;
  logic                    row_last;

  modport source (output valid, output average, output row_last, input ready);
  modport sink (input valid, input average, input row_last, output ready);
endinterface

interface tfwa_cfg_if import tfwa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink (input valid, input addr, input data, output ready);
endinterface

FILE: src/tfwa_cell.sv
`timescale 1ns / 1ps

// One entry of the pending window. Shifts toward the head on a pop.
module tfwa_cell import tfwa_pkg::*; #(
  parameter int W = 16
) (
  input  logic         clk,
  input  cell_ctl_t    ctl,
  input  logic [W-1:0] din,
  input  logic [W-1:0] nbr,
  output logic [W-1:0] q
);

  logic [W-1:0] val_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      val_r <= din;
    end else if (ctl.shift) begin
      val_r <= nbr;
    end
  end

  assign q = val_r;

endmodule

FILE: src/tfwa_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module tfwa_div import tfwa_pkg::*; #(
  parameter int DW = 30,
  parameter int CW = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [CW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quot
);

  localparam int CNT_W = $clog2(DW + 1);

  logic [DW-1:0]    q_r, q_nxt;
  logic [CW-1:0]    rem_r, rem_nxt;
  logic [CW-1:0]    dvs_r, dvs_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [CW:0]      rem_sh;
  logic [CW:0]      diff;
  logic             ge;

  assign rem_sh = {rem_r, q_r[DW-1]};
  assign diff   = rem_sh - {1'b0, dvs_r};
  assign ge     = rem_sh >= {1'b0, dvs_r};

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt   = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
      cnt_nxt = CNT_W'(DW);
      run_nxt = 1'b1;
    end else if (run_r) begin
      q_nxt   = {q_r[DW-2:0], ge};
      rem_nxt = ge ? diff[CW-1:0] : rem_sh[CW-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

FILE: src/thresholded_forward_window_average_top.sv
`timescale 1ns / 1ps

// Channel | Dir | Payload                         | Request taken when
// in_if   | in  | sample[SAMPLE_BITS], row_end    | in_if.valid && in_if.ready
// out_if  | out | average[24] (Q8), row_last      | out_if.valid && out_if.ready
// cfg_if  | in  | addr[2], data[15]               | cfg_if.valid && cfg_if.ready
//
// An input request enters the cell chain and is then checked for due results.
// Each result then passes a check state, the bit-serial divider and a
// hand-over into the output register. Reset is synchronous and active low
// and clears all control state. A stalled output holds its register; the next
// division starts only once that register is free, and a new input request is
// taken while the last result of the previous one still waits.

module thresholded_forward_window_average_top import tfwa_pkg::*; #(
  parameter int MAX_WINDOW  = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  tfwa_in_if.sink    in_if,
  tfwa_out_if.source out_if,
  tfwa_cfg_if.sink   cfg_if
);

  // Fill count width holds 0..MAX_WINDOW. The running sum and its magnitude
  // need that many bits beyond one sample. The dividend carries 8 fraction bits.
  localparam int CW    = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = SAMPLE_BITS + CW;
  localparam int DW    = SUM_W + FRAC_BITS;
  localparam int CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;
  localparam int QW    = (DW > AVG_W + 1) ? DW : AVG_W + 1;

  // Configuration registers.
  logic [WLEN_W-1:0] wlen_r;
  logic [THR_W-1:0]  thr_r;
  logic              use_abs_r;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r    <= WLEN_RESET;
      thr_r     <= THR_RESET;
      use_abs_r <= 1'b0;
    end else if (cfg_if.valid) begin
      case (cfg_reg_t'(cfg_if.addr))
        REG_WINDOW_LEN: wlen_r    <= cfg_if.data[WLEN_W-1:0];
        REG_THRESHOLD:  thr_r     <= cfg_if.data[THR_W-1:0];
        REG_USE_ABS:    use_abs_r <= cfg_if.data[0];
        default: ;
      endcase
    end
  end

  // Effective window: zero acts as one, and lengths above the chain are clamped.
  logic [CW-1:0] w_eff;

  always_comb begin
    if (wlen_r == '0) begin
      w_eff = CW'(1);
    end else if (32'(wlen_r) > MAX_WINDOW) begin
      w_eff = CW'(MAX_WINDOW);
    end else begin
      w_eff = CW'(wlen_r);
    end
  end

  // Thresholding of the incoming sample. The magnitude of the most negative
  // sample wraps to the correct unsigned value in SAMPLE_BITS bits.
  logic [SAMPLE_BITS-1:0] s_mag;
  logic [SAMPLE_BITS-1:0] contrib;

  assign s_mag   = in_if.sample[SAMPLE_BITS-1] ? -in_if.sample : in_if.sample;
  assign contrib = (CMP_W'(s_mag) > CMP_W'(thr_r)) ? in_if.sample : '0;

  // Control state.
  ctl_state_t               state_r, state_nxt;
  logic [CW-1:0]            fill_r, fill_nxt;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic                     row_flag_r, row_flag_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     neg_r, last_r, abs_r;
  logic [AVG_W-1:0]         out_avg_r, out_avg_nxt;
  logic                     out_last_r;

  logic push, pop, div_start, out_load, out_free, emit_want;
  logic div_done;
  logic [DW-1:0] div_quot;
  logic [SUM_W-1:0] sum_mag;
  logic [SAMPLE_BITS-1:0] head;

  assign out_free  = !out_valid_r || out_if.ready;
  assign emit_want = row_flag_r ? (fill_r != '0) : (fill_r >= w_eff);
  assign sum_mag   = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);

  always_comb begin
    state_nxt    = state_r;
    push         = 1'b0;
    pop          = 1'b0;
    div_start    = 1'b0;
    out_load     = 1'b0;
    row_flag_nxt = row_flag_r;
    in_if.ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_if.ready = 1'b1;
        if (in_if.valid) begin
          push         = 1'b1;
          row_flag_nxt = in_if.row_end;
          state_nxt    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!emit_want) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          div_start = 1'b1;
          pop       = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          out_load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Fill count and running sum. Push and pop never fall in the same cycle.
  always_comb begin
    fill_nxt = fill_r;
    sum_nxt  = sum_r;
    if (push) begin
      fill_nxt = fill_r + 1'b1;
      sum_nxt  = sum_r + {{CW{contrib[SAMPLE_BITS-1]}}, contrib};
    end else if (pop) begin
      fill_nxt = fill_r - 1'b1;
      sum_nxt  = sum_r - {{CW{head[SAMPLE_BITS-1]}}, head};
    end
  end

  // Sign handling and saturation of the finished quotient.
  logic [QW-1:0] q_ext;
  logic          neg_eff;

  assign q_ext   = QW'(div_quot);
  assign neg_eff = neg_r && !abs_r;

  always_comb begin
    if (!neg_eff) begin
      out_avg_nxt = (q_ext > QW'(AVG_MAX)) ? AVG_MAX : q_ext[AVG_W-1:0];
    end else begin
      out_avg_nxt = (q_ext > QW'(AVG_MIN)) ? AVG_MIN : AVG_W'(-q_ext);
    end
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && !out_if.ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      sum_r       <= '0;
      row_flag_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      sum_r       <= sum_nxt;
      row_flag_r  <= row_flag_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Attributes of the result under division, and the output register.
  always_ff @(posedge clk) begin
    if (div_start) begin
      neg_r  <= sum_r[SUM_W-1];
      last_r <= row_flag_r && (fill_r == CW'(1));
      abs_r  <= use_abs_r;
    end
    if (out_load) begin
      out_avg_r  <= out_avg_nxt;
      out_last_r <= last_r;
    end
  end

  assign out_if.valid    = out_valid_r;
  assign out_if.average  = out_avg_r;
  assign out_if.row_last = out_last_r;

  // Chain of window cells. Cell 0 holds the oldest pending contribution; a new
  // one lands in the cell at the fill count, and a pop moves every cell one
  // place toward the head.
  logic [SAMPLE_BITS-1:0] cell_q [MAX_WINDOW];

  assign head = cell_q[0];

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    cell_ctl_t              ctl;
    logic [SAMPLE_BITS-1:0] nbr;

    assign ctl.load  = push && (fill_r == CW'(i));
    assign ctl.shift = pop;

    if (i == MAX_WINDOW - 1) begin : g_tail
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_q[i+1];
    end

    tfwa_cell #(
      .W(SAMPLE_BITS)
    ) u_cell (
      .clk (clk),
      .ctl (ctl),
      .din (contrib),
      .nbr (nbr),
      .q   (cell_q[i])
    );
  end

  // Average = |sum| * 256 / count, sign restored afterwards.
  tfwa_div #(
    .DW(DW),
    .CW(CW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({sum_mag, {FRAC_BITS{1'b0}}}),
    .divisor  (fill_r),
    .done     (div_done),
    .quot     (div_quot)
  );

endmodule

FILE: src/tfwa_checker.sv
`timescale 1ns / 1ps

module tfwa_checker import tfwa_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [AVG_W-1:0] out_average,
  input logic             out_row_last
);

  // A result offered under stall stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_average) && $stable(out_row_last))
    else $error("result payload changed while stalled");

  // Each request is checked for due results before the next one is taken.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken on consecutive cycles");

  // Reset leaves no result pending.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind thresholded_forward_window_average_top tfwa_checker u_tfwa_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_if.valid),
  .in_ready     (in_if.ready),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .out_average  (out_if.average),
  .out_row_last (out_if.row_last)
);

FILE: tb/sv/tb_thresholded_forward_window_average_top.sv
`timescale 1ns / 1ps

module tb_thresholded_forward_window_average_top;
  import tfwa_pkg::*;

  localparam int MAX_WINDOW  = 32;
  localparam int SAMPLE_BITS = 16;

  // A quiet stretch of this length outlasts one result from the check to the
  // hand-over, so it means the block has nothing left in flight.
  localparam int DRAIN_CYCLES = 120;

  // Far above the slowest correct run: every request releasing a full
  // window of results, each waiting out a stalled receiver.
  localparam int LIMIT_CYCLES = 2000000;

  logic clk;
  logic rst_n;

  tfwa_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) in_if ();
  tfwa_out_if out_if ();
  tfwa_cfg_if cfg_if ();

  thresholded_forward_window_average_top #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .out_if(out_if),
    .cfg_if(cfg_if)
  );

  // One result of the block, as the checker expects to see it.
  typedef struct packed {
    logic signed [AVG_W-1:0] average;
    logic                    row_last;
  } avg_result_t;

  // Expected averages in the order the block must deliver them.
  avg_result_t avg_expect_q[$];

  // Our own copy of the filter state: the thresholded contributions of the
  // positions still waiting for their window, and their sum.
  logic signed [SAMPLE_BITS-1:0] pend_contrib_q[$];
  longint                        pend_sum;

  // Our own copy of the configuration registers.
  logic [WLEN_W-1:0] cur_wlen;
  logic [THR_W-1:0]  cur_thr;
  logic              cur_abs;

  // Idling knobs, changed between phases.
  int send_idle_pct;
  int recv_stall_pct;

  int error_count;
  int cycle_count;

  // Clock: 10 ns period.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Watchdog. A hung handshake or a missing result ends up here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("[thresholded_forward_window_average_top] ERROR");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------------

  // The window length register saturates: zero behaves as one, anything
  // past the store depth behaves as the full depth.
  function automatic int window_in_force();
    if (cur_wlen == 0) begin
      return 1;
    end
    if (int'(cur_wlen) > MAX_WINDOW) begin
      return MAX_WINDOW;
    end
    return int'(cur_wlen);
  endfunction

  // Produce the average of the oldest pending position and retire it. The
  // divisor is the number of positions still pending, which is what cuts
  // the window short at the end of a row.
  function automatic void retire_oldest(bit last);
    longint avg;
    avg_result_t res;
    avg = 0;
    if (pend_contrib_q.size() != 0) begin
      avg = (pend_sum * 256) / longint'(pend_contrib_q.size());
      pend_sum -= longint'(pend_contrib_q.pop_front());
    end
    if (cur_abs && avg < 0) begin
      avg = -avg;
    end
    // Only the magnitude of the most negative average can overflow.
    if (avg > 64'sd8388607) begin
      avg = 64'sd8388607;
    end
    if (avg < -64'sd8388608) begin
      avg = -64'sd8388608;
    end
    res.average  = avg[AVG_W-1:0];
    res.row_last = last;
    avg_expect_q.push_back(res);
  endfunction

  // Advance the predictor by one accepted sample.
  function automatic void predict_averages(logic signed [SAMPLE_BITS-1:0] s, logic re);
    int mag;
    int w;
    int n;
    logic signed [SAMPLE_BITS-1:0] contrib;
    mag = (s < 0) ? -int'(s) : int'(s);
    // The threshold is applied once, with the value in force right now.
    contrib = (mag > int'(cur_thr)) ? s : '0;
    w = window_in_force();
    n = 0;
    if (pend_contrib_q.size() < MAX_WINDOW) begin
      pend_contrib_q.push_back(contrib);
      pend_sum += longint'(contrib);
    end
    if (re) begin
      // Row end flushes every pending position; the last one closes the row.
      while (pend_contrib_q.size() > 0 && n < MAX_WINDOW) begin
        retire_oldest(pend_contrib_q.size() == 1);
        n++;
      end
      pend_contrib_q.delete();
      pend_sum = 0;
    end else begin
      // A window that was shrunk mid-row may release several results here.
      while (pend_contrib_q.size() >= w && n < MAX_WINDOW) begin
        retire_oldest(1'b0);
        n++;
      end
    end
  endfunction

  // ------------------------------------------------------------------------
  // Result checker and receiver back-pressure
  // ------------------------------------------------------------------------

  // Each accepted result is matched against the oldest expectation. The
  // ready for the next edge is drawn in the same block, so it only ever gets
  // one assignment per edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (avg_expect_q.size() == 0) begin
          $error("unexpected result: average %0d row_last %0b",
                 out_if.average, out_if.row_last);
          error_count++;
        end else begin
          avg_result_t exp_res;
          exp_res = avg_expect_q.pop_front();
          if (out_if.average !== exp_res.average) begin
            $error("average mismatch: expected %0d, actual %0d",
                   exp_res.average, out_if.average);
            error_count++;
          end
          if (out_if.row_last !== exp_res.row_last) begin
            $error("row_last mismatch: expected %0b, actual %0b",
                   exp_res.row_last, out_if.row_last);
            error_count++;
          end
        end
      end
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ------------------------------------------------------------------------
  // Shared drivers
  // ------------------------------------------------------------------------

  // Send one sample request. Valid is left high afterwards so that a
  // back-to-back request never sees valid lowered and raised in one step;
  // the idle loop or stop_sending drops it.
  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic re);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.sample  <= s;
    in_if.row_end <= re;
    predict_averages(s, re);
    do begin
      @(posedge clk);
    end while (!in_if.ready);
  endtask

  task automatic stop_sending();
    in_if.valid <= 1'b0;
  endtask

  // Wait until every expected result has arrived, then give the block time
  // to finish a request that released no result.
  task automatic wait_idle();
    while (avg_expect_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.addr  <= idx;
    cfg_if.data  <= val;
    do begin
      @(posedge clk);
    end while (!cfg_if.ready);
    case (idx)
      REG_WINDOW_LEN: cur_wlen = val[WLEN_W-1:0];
      REG_THRESHOLD:  cur_thr  = val[THR_W-1:0];
      REG_USE_ABS:    cur_abs  = val[0];
      default: ;
    endcase
  endtask

  // Quiesce the block, then write all three registers in one burst.
  task automatic reconfigure(input int wlen, input int thr, input bit use_abs);
    stop_sending();
    wait_idle();
    write_reg(REG_WINDOW_LEN, CFG_DATA_W'(wlen));
    write_reg(REG_THRESHOLD, CFG_DATA_W'(thr));
    write_reg(REG_USE_ABS, CFG_DATA_W'(use_abs));
    cfg_if.valid <= 1'b0;
  endtask

  // ------------------------------------------------------------------------
  // Directed tests
  // ------------------------------------------------------------------------

  // Reset values: window 8, threshold 3, signed output. Samples of magnitude
  // exactly 3 must be dropped from the sum, 4 must be kept, and the sample
  // extremes go through a full window.
  task automatic test_reset_defaults();
    send_sample(16'sd3, 1'b0);
    send_sample(-16'sd3, 1'b0);
    send_sample(16'sd4, 1'b0);
    send_sample(-16'sd4, 1'b0);
    send_sample(16'sd32767, 1'b0);
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sd100, 1'b0);
    send_sample(16'sd0, 1'b1);
  endtask

  // A window of one releases a result per sample, and a one-sample row
  // gives a single result that closes the row.
  task automatic test_unit_window();
    reconfigure(1, 0, 1'b0);
    send_sample(16'sd5, 1'b1);
    send_sample(-16'sd7, 1'b0);
    send_sample(16'sd9, 1'b1);
  endtask

  // Window lengths outside the legal range saturate at either end.
  task automatic test_window_clamp();
    reconfigure(0, 3, 1'b0);
    send_sample(-16'sd20, 1'b1);
    reconfigure(63, 3, 1'b0);
    send_sample(16'sd1000, 1'b0);
    send_sample(-16'sd1000, 1'b0);
    send_sample(16'sd500, 1'b1);
  endtask

  // With the magnitude mode on, the most negative average cannot be negated
  // and must clip to the largest positive value.
  task automatic test_abs_saturation();
    reconfigure(1, 0, 1'b1);
    send_sample(-16'sd32768, 1'b0);
    send_sample(-16'sd5, 1'b0);
    send_sample(16'sd32767, 1'b1);
  endtask

  // Shrinking the window in the middle of a row makes the next sample
  // release the backlog in one go.
  task automatic test_window_shrink_mid_row();
    reconfigure(8, 3, 1'b0);
    send_sample(16'sd11, 1'b0);
    send_sample(-16'sd22, 1'b0);
    send_sample(16'sd33, 1'b0);
    reconfigure(2, 3, 1'b0);
    send_sample(16'sd44, 1'b0);
    send_sample(-16'sd55, 1'b1);
  endtask

  // A threshold change mid-row applies to new samples only; samples already
  // pending keep the verdict they got on arrival.
  task automatic test_threshold_mid_row();
    reconfigure(8, 50, 1'b0);
    send_sample(16'sd40, 1'b0);
    send_sample(-16'sd60, 1'b0);
    reconfigure(8, 30, 1'b0);
    send_sample(16'sd40, 1'b1);
  endtask

  // ------------------------------------------------------------------------
  // Random test
  // ------------------------------------------------------------------------

  // Samples cluster at the extremes and right around the threshold, with
  // the rest spread over the whole range.
  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    int t;
    case ($urandom_range(9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2, 3: begin
        t = int'(cur_thr) + $urandom_range(2) - 1;
        if (t < 0) begin
          t = 0;
        end
        if (t > 32767) begin
          t = 32767;
        end
        return $urandom_range(1) ? SAMPLE_BITS'(t) : SAMPLE_BITS'(-t);
      end
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // Rows of random length under a sequence of settings and idling modes.
  // A phase may stop in the middle of a row, so the next configuration
  // lands on pending positions.
  task automatic test_random_rows();
    int phase;
    int sent;
    int row_len;
    int wlen;
    int thr;
    bit abs_mode;
    bit finish_row;
    for (phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      case (phase)
        0: begin wlen = 32; thr = 32767; end
        1: begin wlen = 1;  thr = 0;     end
        2: begin wlen = 0;  thr = $urandom_range(200); end
        3: begin wlen = 63; thr = $urandom_range(32767); end
        default: begin
          wlen = $urandom_range(1, 32);
          thr  = $urandom_range(1) ? $urandom_range(200) : $urandom_range(32767);
        end
      endcase
      abs_mode = (phase < 2) ? phase[0] : $urandom_range(1);
      reconfigure(wlen, thr, abs_mode);

      sent = 0;
      while (sent < 6) begin
        // Mostly short rows, now and then a long one that can exceed the deepest window.
        row_len = $urandom_range(3) ? $urandom_range(1, 12) : $urandom_range(20, 40);
        finish_row = (phase == 7) || (sent + row_len < 6) || $urandom_range(1);
        for (int i = 0; i < row_len; i++) begin
          send_sample(pick_sample(), finish_row && (i == row_len - 1));
          sent++;
        end
      end
    end
    // Close whatever row is still open so that every position is flushed.
    send_sample(pick_sample(), 1'b1);
  endtask

  // ------------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------------

  initial begin
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    pend_sum       = 0;
    cur_wlen       = WLEN_RESET;
    cur_thr        = THR_RESET;
    cur_abs        = 1'b0;

    rst_n          = 1'b0;
    in_if.valid    = 1'b0;
    in_if.sample   = '0;
    in_if.row_end  = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.addr    = REG_WINDOW_LEN;
    cfg_if.data    = '0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed cases run with no idling; the random phases vary it.
    test_reset_defaults();
    test_unit_window();
    test_window_clamp();
    test_abs_saturation();
    test_window_shrink_mid_row();
    test_threshold_mid_row();
    test_random_rows();

    // Let everything drain, then allow a little more for stray results.
    stop_sending();
    wait_idle();

    if (error_count == 0) begin
      $display("[thresholded_forward_window_average_top] OK");
    end else begin
      $display("[thresholded_forward_window_average_top] ERROR");
    end
    $finish;
  end

endmodule
